[hdl/tsbe_pkg.sv]
// shared types and constants of the tensor slice broadcast engine
`default_nettype none
package tsbe_pkg;

	localparam int NUM_DIM_REGS = 4;
	localparam int DIM_REG_W    = 4;
	localparam int PADDR_W      = 5;
	localparam int REG_IDX_W    = 3;
	localparam int DATA_W       = 32;

	localparam logic [REG_IDX_W-1:0] REG_DIM_SIZE_0   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DIM_SIZE_1   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DIM_SIZE_2   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DIM_SIZE_3   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_COMBINE_MODE = 3'd4;

	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_APPLY = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;

	localparam logic [DATA_W-1:0] Q_ONE  = 32'h0001_0000;
	localparam logic [DATA_W-1:0] Q_ZERO = 32'h0000_0000;

	typedef struct packed {
		logic [1:0]  func;
		logic [1:0]  dim_select;
		logic [2:0]  slice_index;
		logic signed [31:0] alpha_value;
		logic [11:0] read_address;
	} req_t;

	typedef struct packed {
		logic signed [31:0] element_value;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		logic [NUM_DIM_REGS-1:0][DIM_REG_W-1:0] dim_size;
		logic                                   combine_mode;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic clear_we;
		logic walk_init;
		logic walk_step;
		logic rd_issue;
		logic respond;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       apply_bad;
		logic       read_bad;
		logic       clr_last;
		logic       walk_last;
		logic       pipe_empty;
	} sts_t;

endpackage
`default_nettype wire

[hdl/tsbe_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module tsbe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[hdl/tsbe_ctrl.sv]
// controller state machine of the tensor slice broadcast engine
`default_nettype none
module tsbe_ctrl #(
	parameter int NUM_DIMS = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire tsbe_pkg::sts_t sts,
	output tsbe_pkg::cmd_t     cmd,
	output logic               busy
);

	localparam int SCW = $clog2(NUM_DIMS + 1);

	typedef enum logic [8:0] {
		S_IDLE      = 9'b000000001,
		S_SETUP     = 9'b000000010,
		S_CLEAR     = 9'b000000100,
		S_WALK_INIT = 9'b000001000,
		S_WALK      = 9'b000010000,
		S_DRAIN     = 9'b000100000,
		S_RD_ISSUE  = 9'b001000000,
		S_RD_DATA   = 9'b010000000,
		S_RESP      = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic [SCW-1:0] set_q;
	logic setup_last;

	assign setup_last = (set_q == SCW'(NUM_DIMS - 1));
	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			set_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SETUP) begin
				set_q <= set_q + SCW'(1);
			end else begin
				set_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_SETUP;
				end
			end
			S_SETUP: begin
				if (setup_last) begin
					case (sts.func)
						tsbe_pkg::FUNC_CLEAR: state_d = S_CLEAR;
						tsbe_pkg::FUNC_APPLY: state_d = sts.apply_bad ? S_RESP : S_WALK_INIT;
						tsbe_pkg::FUNC_READ:  state_d = sts.read_bad ? S_RESP : S_RD_ISSUE;
						default:              state_d = S_RESP;
					endcase
				end
			end
			S_CLEAR: begin
				cmd.clear_we = 1'b1;
				if (sts.clr_last) begin
					state_d = S_RESP;
				end
			end
			S_WALK_INIT: begin
				cmd.walk_init = 1'b1;
				state_d = S_WALK;
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (sts.pipe_empty) begin
					state_d = S_RESP;
				end
			end
			S_RD_ISSUE: begin
				cmd.rd_issue = 1'b1;
				state_d = S_RD_DATA;
			end
			S_RD_DATA: begin
				cmd.respond = 1'b1;
				state_d = S_IDLE;
			end
			S_RESP: begin
				cmd.respond = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[hdl/tsbe_dp.sv]
// datapath: strides, slice walker, read-modify-write pipeline and tensor memory
`default_nettype none
module tsbe_dp #(
	parameter int MAX_EXTENT  = 8,
	parameter int NUM_DIMS    = 4,
	parameter int STORE_DEPTH = 4096
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tsbe_pkg::cfg_t cfg,
	input  wire tsbe_pkg::req_t req,
	input  wire tsbe_pkg::cmd_t cmd,
	output tsbe_pkg::sts_t      sts,
	output tsbe_pkg::rsp_t      rsp
);

	localparam int EW = $clog2(MAX_EXTENT + 1);
	localparam int CW = $clog2(MAX_EXTENT);
	localparam int SW = NUM_DIMS * EW;
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int LW = (SW > 17) ? SW : 17;

	tsbe_pkg::req_t req_q;

	logic [EW-1:0]       ext_w    [NUM_DIMS];
	logic [SW-1:0]       stride_w [NUM_DIMS];
	logic [SW-1:0]       stride_q [NUM_DIMS];
	logic [CW-1:0]       coord_q  [NUM_DIMS];
	logic [SW-1:0]       off_q    [NUM_DIMS];
	logic [NUM_DIMS-1:0] sel_w;
	logic [NUM_DIMS-1:0] at_max;
	logic [NUM_DIMS:0]   carry;
	logic [SW-1:0]       flat;
	logic [EW-1:0]       ext_sel;
	logic [SW-1:0]       len;

	logic [AW-1:0] clr_q;
	logic          sat_q;

	logic          vld_s1, vld_s2, vld_s3;
	logic [AW-1:0] addr_s1, addr_s2, addr_s3;
	logic signed [63:0] res_s3;

	logic [31:0]        ram_rdata;
	logic [AW-1:0]      ram_raddr;
	logic [AW-1:0]      ram_waddr;
	logic [31:0]        ram_wdata;
	logic               ram_we;

	logic signed [31:0] elem;
	logic signed [63:0] prod;
	logic signed [63:0] sum;
	logic signed [63:0] shifted;
	logic [31:0]        sat_val;
	logic               sat_hit;

	genvar gd;
	generate
		for (gd = 0; gd < NUM_DIMS; gd++) begin : g_dim
			if (gd < tsbe_pkg::NUM_DIM_REGS) begin : g_cfg
				assign ext_w[gd] = (cfg.dim_size[gd] == '0) ? EW'(1) :
					((32'(cfg.dim_size[gd]) > 32'(MAX_EXTENT)) ? EW'(MAX_EXTENT) :
					EW'(cfg.dim_size[gd]));
			end else begin : g_one
				assign ext_w[gd] = EW'(1);
			end

			if (gd == 0) begin : g_first
				assign stride_w[gd] = SW'(1);
			end else begin : g_rest
				assign stride_w[gd] = stride_q[gd-1];
			end

			always_ff @(posedge clk) begin
				stride_q[gd] <= stride_w[gd] * SW'(ext_w[gd]);
			end

			assign sel_w[gd]  = (int'(req_q.dim_select) == gd);
			assign at_max[gd] = sel_w[gd] || (coord_q[gd] == CW'(ext_w[gd] - EW'(1)));
			assign carry[gd+1] = carry[gd] & at_max[gd];

			always_ff @(posedge clk) begin
				if (cmd.walk_init) begin
					coord_q[gd] <= '0;
					off_q[gd]   <= sel_w[gd] ? SW'(req_q.slice_index) * stride_w[gd] : '0;
				end else if (cmd.walk_step && !sel_w[gd] && carry[gd]) begin
					if (at_max[gd]) begin
						coord_q[gd] <= '0;
						off_q[gd]   <= '0;
					end else begin
						coord_q[gd] <= coord_q[gd] + CW'(1);
						off_q[gd]   <= off_q[gd] + stride_w[gd];
					end
				end
			end
		end
	endgenerate

	assign carry[0] = 1'b1;
	assign len = stride_q[NUM_DIMS-1];

	always_comb begin
		flat = '0;
		ext_sel = EW'(1);
		for (int d = 0; d < NUM_DIMS; d++) begin
			flat = flat + off_q[d];
			if (int'(req_q.dim_select) == d) begin
				ext_sel = ext_w[d];
			end
		end
	end

	// request capture, clear sweep and saturation flag
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			clr_q <= '0;
		end else if (cmd.clear_we) begin
			clr_q <= clr_q + AW'(1);
		end
		if (cmd.load) begin
			sat_q <= 1'b0;
		end else if (vld_s3 && sat_hit) begin
			sat_q <= 1'b1;
		end
	end

	// read-modify-write pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= cmd.walk_step && (LW'(flat) < LW'(STORE_DEPTH));
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= AW'(flat);
		addr_s2 <= addr_s1;
		addr_s3 <= addr_s2;
		res_s3  <= cfg.combine_mode ? prod : sum;
	end

	assign elem = $signed(ram_rdata);
	assign prod = elem * req_q.alpha_value;
	assign sum  = 64'(elem) + 64'(req_q.alpha_value);

	always_comb begin
		shifted = cfg.combine_mode ? (res_s3 >>> 16) : res_s3;
		sat_hit = 1'b0;
		if (shifted > 64'sd2147483647) begin
			sat_val = 32'h7FFF_FFFF;
			sat_hit = 1'b1;
		end else if (shifted < -64'sd2147483648) begin
			sat_val = 32'h8000_0000;
			sat_hit = 1'b1;
		end else begin
			sat_val = shifted[31:0];
		end
	end

	assign ram_we    = cmd.clear_we || vld_s3;
	assign ram_waddr = cmd.clear_we ? clr_q : addr_s3;
	assign ram_wdata = cmd.clear_we ?
		(cfg.combine_mode ? tsbe_pkg::Q_ONE : tsbe_pkg::Q_ZERO) : sat_val;
	assign ram_raddr = cmd.rd_issue ? AW'(req_q.read_address) : addr_s1;

	tsbe_ram #(
		.WIDTH(32),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign sts.func       = req_q.func;
	assign sts.apply_bad  = (int'(req_q.dim_select) >= NUM_DIMS) ||
		(int'(req_q.slice_index) >= int'(ext_sel));
	assign sts.read_bad   = (LW'(req_q.read_address) >= LW'(len)) ||
		(LW'(req_q.read_address) >= LW'(STORE_DEPTH));
	assign sts.clr_last   = (clr_q == AW'(STORE_DEPTH - 1));
	assign sts.walk_last  = carry[NUM_DIMS];
	assign sts.pipe_empty = !vld_s1 && !vld_s2 && !vld_s3;

	always_comb begin
		rsp.element_value = '0;
		rsp.status = tsbe_pkg::ST_OK;
		case (req_q.func)
			tsbe_pkg::FUNC_CLEAR: begin
				rsp.status = tsbe_pkg::ST_OK;
			end
			tsbe_pkg::FUNC_APPLY: begin
				if (sts.apply_bad) begin
					rsp.status = tsbe_pkg::ST_RANGE;
				end else if (sat_q) begin
					rsp.status = tsbe_pkg::ST_SAT;
				end
			end
			tsbe_pkg::FUNC_READ: begin
				if (sts.read_bad) begin
					rsp.status = tsbe_pkg::ST_RANGE;
				end else begin
					rsp.element_value = $signed(ram_rdata);
				end
			end
			default: begin
				rsp.status = tsbe_pkg::ST_RANGE;
			end
		endcase
	end

endmodule
`default_nettype wire

[hdl/tensor_slice_broadcast_engine.sv]
// clear writes every store word, read fetches one element, and apply walks the n
// elements of the selected slice, where n is the product of the extents not selected
// (one element read-modify-write per cycle through the single memory write port)
// an out-of-range request answers straight from setup; one request at a time
// results leave as a one-cycle done strobe; the receiver cannot stall
// arst_n clears control and the registers to extent 1 and add mode; memory is not cleared
`default_nettype none
module tensor_slice_broadcast_engine #(
	parameter int MAX_EXTENT  = 8,
	parameter int NUM_DIMS    = 4,
	parameter int STORE_DEPTH = 4096
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [tsbe_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [tsbe_pkg::DATA_W-1:0]     pwdata,
	output logic      [tsbe_pkg::DATA_W-1:0]     prdata,
	output logic                                 pready,
	input  wire logic                            start,
	input  wire tsbe_pkg::req_t                  req,
	output logic                                 busy,
	output logic                                 done,
	output tsbe_pkg::rsp_t                       rsp
);

	tsbe_pkg::cfg_t cfg_q;
	tsbe_pkg::cmd_t cmd;
	tsbe_pkg::sts_t sts;
	tsbe_pkg::rsp_t rsp_w;
	tsbe_pkg::rsp_t rsp_q;
	logic           done_q;
	logic           wr_en;
	logic [tsbe_pkg::REG_IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[tsbe_pkg::PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < tsbe_pkg::NUM_DIM_REGS; d++) begin
				cfg_q.dim_size[d] <= tsbe_pkg::DIM_REG_W'(1);
			end
			cfg_q.combine_mode <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				tsbe_pkg::REG_DIM_SIZE_0:   cfg_q.dim_size[0]  <= pwdata[3:0];
				tsbe_pkg::REG_DIM_SIZE_1:   cfg_q.dim_size[1]  <= pwdata[3:0];
				tsbe_pkg::REG_DIM_SIZE_2:   cfg_q.dim_size[2]  <= pwdata[3:0];
				tsbe_pkg::REG_DIM_SIZE_3:   cfg_q.dim_size[3]  <= pwdata[3:0];
				tsbe_pkg::REG_COMBINE_MODE: cfg_q.combine_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			tsbe_pkg::REG_DIM_SIZE_0:   prdata = {28'd0, cfg_q.dim_size[0]};
			tsbe_pkg::REG_DIM_SIZE_1:   prdata = {28'd0, cfg_q.dim_size[1]};
			tsbe_pkg::REG_DIM_SIZE_2:   prdata = {28'd0, cfg_q.dim_size[2]};
			tsbe_pkg::REG_DIM_SIZE_3:   prdata = {28'd0, cfg_q.dim_size[3]};
			tsbe_pkg::REG_COMBINE_MODE: prdata = {31'd0, cfg_q.combine_mode};
			default:                    prdata = '0;
		endcase
	end

	tsbe_ctrl #(
		.NUM_DIMS(NUM_DIMS)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	tsbe_dp #(
		.MAX_EXTENT (MAX_EXTENT),
		.NUM_DIMS   (NUM_DIMS),
		.STORE_DEPTH(STORE_DEPTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.req   (req),
		.cmd   (cmd),
		.sts   (sts),
		.rsp   (rsp_w)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.respond;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			rsp_q <= rsp_w;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in flight");

	a_accept_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted request did not start work");

	a_respond_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.respond |=> (!busy && done))
		else $error("response did not return controller to idle");
`endif

endmodule
`default_nettype wire

[bench/tensor_slice_broadcast_engine_tb.sv]
// self-checking bench for the tensor slice broadcast engine: directed and random requests
`timescale 1ns / 1ps
module tensor_slice_broadcast_engine_tb;
	import tsbe_pkg::*;

	localparam int MAX_EXTENT     = 8;
	localparam int NUM_DIMS       = 4;
	localparam int STORE_DEPTH    = 4096;
	localparam int CLK_PERIOD     = 4;
	localparam int RANDOM_ITEMS   = 1150;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TAIL_CYCLES    = 32;

	localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
	localparam logic       MODE_ADD     = 1'b0;
	localparam logic       MODE_MUL     = 1'b1;

	localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
	localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

	class tensor_mirror;
		logic [DATA_W-1:0]    store [STORE_DEPTH];
		logic [DIM_REG_W-1:0] dim_reg [NUM_DIM_REGS];
		logic                 mode;
		bit                   saturated;
		rsp_t                 owed_rsp [$];
		int                   errors;

		function new();
			foreach (dim_reg[d]) dim_reg[d] = 4'd1;
			mode = MODE_ADD;
			errors = 0;
		endfunction

		function void write_register(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] word);
			if (idx == REG_COMBINE_MODE) begin
				mode = word[0];
			end else begin
				dim_reg[idx] = word[DIM_REG_W-1:0];
			end
		endfunction

		function int extent(int d);
			int e;
			e = dim_reg[d];
			if (e == 0) e = 1;
			if (e > MAX_EXTENT) e = MAX_EXTENT;
			return e;
		endfunction

		function int tensor_length();
			int len;
			len = 1;
			for (int d = 0; d < NUM_DIMS; d++) len *= extent(d);
			return len;
		endfunction

		function logic [DATA_W-1:0] combine(logic signed [31:0] elem, logic signed [31:0] alpha);
			logic signed [63:0] wide;
			if (mode == MODE_ADD) begin
				wide = elem + alpha;
			end else begin
				wide = elem * alpha;
				wide = wide >>> 16;
			end
			if (wide > SAT_HI) begin
				saturated = 1'b1;
				return 32'h7FFF_FFFF;
			end
			if (wide < SAT_LO) begin
				saturated = 1'b1;
				return 32'h8000_0000;
			end
			return wide[31:0];
		endfunction

		function void note_request(req_t r);
			rsp_t want;
			int   len;
			int   ext;
			int   stride;
			want = '0;
			len = tensor_length();
			case (r.func)
				FUNC_CLEAR: begin
					for (int i = 0; i < STORE_DEPTH; i++) store[i] = mode ? Q_ONE : Q_ZERO;
				end
				FUNC_APPLY: begin
					ext = extent(r.dim_select);
					if (r.slice_index >= ext) begin
						want.status = ST_RANGE;
					end else begin
						stride = 1;
						saturated = 1'b0;
						for (int d = 0; d < r.dim_select; d++) stride *= extent(d);
						for (int f = 0; f < len && f < STORE_DEPTH; f++)
							if ((f / stride) % ext == r.slice_index)
								store[f] = combine(store[f], r.alpha_value);
						if (saturated) want.status = ST_SAT;
					end
				end
				FUNC_READ: begin
					if (r.read_address >= len) want.status = ST_RANGE;
					else want.element_value = store[r.read_address];
				end
				default: want.status = ST_RANGE;
			endcase
			owed_rsp.push_back(want);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (owed_rsp.size() == 0) begin
				$error("response with none owed: element_value %h status %0d",
					got.element_value, got.status);
				errors++;
				return;
			end
			want = owed_rsp.pop_front();
			if (got.element_value !== want.element_value) begin
				$error("element_value: expected %h, actual %h", want.element_value,
					got.element_value);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
		endfunction

		function int pending();
			return owed_rsp.size();
		endfunction
	endclass

	logic                 clk     = 1'b0;
	logic                 arst_n  = 1'b0;
	logic                 psel    = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite  = 1'b0;
	logic [PADDR_W-1:0]   paddr   = '0;
	logic [DATA_W-1:0]    pwdata  = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;
	logic                 start   = 1'b0;
	req_t                 req     = '0;
	logic                 busy;
	logic                 done;
	rsp_t                 rsp;

	tensor_mirror mirror;
	bit           gaps_on = 1'b1;
	int           sent_random = 0;
	int           idle_cycles = 0;

	tensor_slice_broadcast_engine #(
		.MAX_EXTENT  (MAX_EXTENT),
		.NUM_DIMS    (NUM_DIMS),
		.STORE_DEPTH (STORE_DEPTH)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.done    (done),
		.rsp     (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) mirror.check_response(rsp);
		if (!arst_n || done || (start && !busy)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tensor_slice_broadcast_engine test failed");
			$finish;
		end
	end

	function automatic req_t mk(logic [1:0] f, logic [1:0] dsel, logic [2:0] sidx,
			logic [31:0] alpha, logic [11:0] addr);
		req_t r;
		r.func = f;
		r.dim_select = dsel;
		r.slice_index = sidx;
		r.alpha_value = alpha;
		r.read_address = addr;
		return r;
	endfunction

	task automatic issue(input req_t r);
		@(posedge clk);
		if (gaps_on && $urandom_range(0, 99) < 30) begin
			while (busy) @(posedge clk);
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		start <= 1'b0;
		mirror.note_request(r);
	endtask

	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] word);
		while (mirror.pending() != 0 || busy) @(posedge clk);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		mirror.write_register(idx, word);
	endtask

	task automatic set_shape(input int e0, input int e1, input int e2, input int e3,
			input logic mode);
		apb_write(REG_DIM_SIZE_0, ($urandom() & 32'hFFFF_FFF0) | 32'(e0));
		apb_write(REG_DIM_SIZE_1, ($urandom() & 32'hFFFF_FFF0) | 32'(e1));
		apb_write(REG_DIM_SIZE_2, ($urandom() & 32'hFFFF_FFF0) | 32'(e2));
		apb_write(REG_DIM_SIZE_3, ($urandom() & 32'hFFFF_FFF0) | 32'(e3));
		apb_write(REG_COMBINE_MODE, ($urandom() & 32'hFFFF_FFFE) | 32'(mode));
	endtask

	task automatic random_phase();
		int          ext_reg [4];
		bit          big;
		logic        mode;
		int          count;
		int          pick;
		int          len;
		req_t        r;
		logic [31:0] alpha;
		big = ($urandom_range(0, 7) == 0);
		for (int d = 0; d < 4; d++) begin
			if (big) ext_reg[d] = $urandom_range(8, 15);
			else case ($urandom_range(0, 9))
				0: ext_reg[d] = 0;
				1: ext_reg[d] = $urandom_range(8, 15);
				default: ext_reg[d] = $urandom_range(1, 4);
			endcase
		end
		mode = $urandom_range(0, 1);
		set_shape(ext_reg[0], ext_reg[1], ext_reg[2], ext_reg[3], mode);
		if ($urandom_range(0, 2) == 0) issue(mk(FUNC_CLEAR, 0, 0, $urandom(), $urandom()));
		len = mirror.tensor_length();
		count = big ? $urandom_range(8, 16) : $urandom_range(15, 45);
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(0, 19))
				0, 1, 2: alpha = $urandom();
				3, 4: case ($urandom_range(0, 3))
					0: alpha = 32'h7FFF_FFFF;
					1: alpha = 32'h8000_0000;
					2: alpha = 32'h0000_0000;
					default: alpha = (mode == MODE_MUL) ? Q_ONE : 32'hFFFF_FFFF;
				endcase
				default: alpha = (mode == MODE_MUL)
					? Q_ONE + 32'($urandom_range(0, 32767)) - 32'd16384
					: 32'($urandom_range(0, 32'h0007_FFFF)) - 32'h0004_0000;
			endcase
			r = mk(FUNC_READ, $urandom(), $urandom(), alpha, $urandom());
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				r.func = FUNC_CLEAR;
			end else if (pick < 5) begin
				r.func = FUNC_UNKNOWN;
			end else if (pick < 50) begin
				r.func = FUNC_APPLY;
				if ($urandom_range(0, 4) != 0)
					r.slice_index = $urandom_range(0, mirror.extent(r.dim_select) - 1);
			end else if ($urandom_range(0, 4) != 0) begin
				r.read_address = $urandom_range(0, len - 1);
			end
			gaps_on = !(sent_random >= 500 && sent_random < 700);
			issue(r);
			sent_random++;
		end
	endtask

	initial begin
		mirror = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset shape: a single element
		issue(mk(FUNC_CLEAR, 0, 0, 32'h0, 12'h0));
		issue(mk(FUNC_READ, 0, 0, 32'h0, 12'h000));
		issue(mk(FUNC_APPLY, 0, 0, 32'h7FFF_FFFF, 12'h0));
		issue(mk(FUNC_APPLY, 0, 0, 32'h0000_0001, 12'h0));
		issue(mk(FUNC_READ, 0, 0, 32'h0, 12'h000));
		issue(mk(FUNC_READ, 0, 0, 32'h0, 12'hFFF));
		issue(mk(FUNC_UNKNOWN, 2'd3, 3'd7, 32'hFFFF_FFFF, 12'hFFF));
		issue(mk(FUNC_APPLY, 1, 1, 32'h0001_0000, 12'h0));

		// zero extent reads as 1, oversized extent as the maximum
		set_shape(0, 15, 9, 2, MODE_MUL);
		issue(mk(FUNC_CLEAR, 0, 0, 32'h0, 12'h0));
		issue(mk(FUNC_APPLY, 1, 7, 32'h8000_0000, 12'h0));
		issue(mk(FUNC_APPLY, 1, 7, 32'h8000_0000, 12'h0));
		issue(mk(FUNC_APPLY, 2, 3, 32'hFFFF_FFFF, 12'h0));
		issue(mk(FUNC_APPLY, 3, 1, 32'h0000_8000, 12'h0));
		issue(mk(FUNC_APPLY, 3, 2, 32'h0000_8000, 12'h0));
		issue(mk(FUNC_APPLY, 0, 1, 32'h0000_8000, 12'h0));
		issue(mk(FUNC_READ, 0, 0, 32'h0, 12'd95));
		issue(mk(FUNC_READ, 0, 0, 32'h0, 12'd127));
		issue(mk(FUNC_READ, 0, 0, 32'h0, 12'd128));

		// full store, add mode over multiplied contents
		set_shape(8, 8, 8, 8, MODE_ADD);
		issue(mk(FUNC_APPLY, 3, 7, 32'h8000_0000, 12'h0));
		issue(mk(FUNC_APPLY, 3, 7, 32'h8000_0000, 12'h0));
		issue(mk(FUNC_READ, 0, 0, 32'h0, 12'hFFF));
		issue(mk(FUNC_APPLY, 0, 5, 32'h0001_8000, 12'h0));
		issue(mk(FUNC_READ, 0, 0, 32'h0, 12'hAAA));
		issue(mk(FUNC_READ, 0, 0, 32'h0, 12'h555));

		while (sent_random < RANDOM_ITEMS) random_phase();

		while (mirror.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mirror.errors == 0) begin
			$display("tensor_slice_broadcast_engine test passed");
		end else begin
			$display("tensor_slice_broadcast_engine test failed");
		end
		$finish;
	end

endmodule
